FILE: hw/rtl/hcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_pkg
// Shared constants, widths and types of the HSI color fade block.
// ----------------------------------------------------------------------------
package hcf_pkg;

  localparam int unsigned COLOR_FRAC_BITS = 16;
  localparam int unsigned STEP_COUNT_BITS = 16;

  // color field: Q(FRAC) plus one integer bit
  localparam int unsigned COLOR_W = COLOR_FRAC_BITS + 1;
  // signed color distance, including the hue direction offset
  localparam int unsigned DIST_W  = COLOR_W + 2;
  // divider dividend / quotient magnitude
  localparam int unsigned MAG_W   = COLOR_FRAC_BITS + 2;
  // signed per-step delta
  localparam int unsigned STEP_W  = MAG_W + 1;
  // signed running color
  localparam int unsigned ACC_W   = COLOR_FRAC_BITS + 5;

  localparam int unsigned ONE_Q      = 1 << COLOR_FRAC_BITS;
  localparam int unsigned HALF_Q     = ONE_Q / 2;
  localparam int unsigned LOW_THRESH = (ONE_Q + 9) / 10;

  localparam logic signed [DIST_W-1:0] ONE_D  = DIST_W'(ONE_Q);
  localparam logic signed [DIST_W-1:0] HALF_D = DIST_W'(HALF_Q);
  localparam logic signed [ACC_W-1:0]  ONE_A  = ACC_W'(ONE_Q);
  localparam logic [COLOR_W-1:0]       LOW_C  = COLOR_W'(LOW_THRESH);

  localparam int unsigned DIV_CNT_W = $clog2(MAG_W);
  localparam int unsigned DIV_LAST  = MAG_W - 1;

  localparam int unsigned LANES = 3;
  localparam int unsigned LANE_HUE = 0;
  localparam int unsigned LANE_SAT = 1;
  localparam int unsigned LANE_INT = 2;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_TICK  = 1'b1
  } hcf_action_e;

  typedef struct packed {
    logic [COLOR_W-1:0]         start_hue;
    logic [COLOR_W-1:0]         start_saturation;
    logic [COLOR_W-1:0]         start_intensity;
    logic [COLOR_W-1:0]         target_hue;
    logic [COLOR_W-1:0]         target_saturation;
    logic [COLOR_W-1:0]         target_intensity;
    logic [STEP_COUNT_BITS-1:0] step_count;
    logic                       shortest_path;
    logic                       positive_direction;
  } hcf_start_t;

  typedef struct packed {
    logic [COLOR_W-1:0] hue;
    logic [COLOR_W-1:0] saturation;
    logic [COLOR_W-1:0] intensity;
    logic               fading;
  } hcf_result_t;

  typedef struct packed {
    logic start;     // load a new fade, seed the dividers
    logic tick;      // advance one frame
    logic div_step;  // one restoring divide step on every lane
    logic div_sign;  // apply sign, store per-step deltas
  } hcf_cmd_t;

endpackage

FILE: hw/rtl/hcf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_if
// Valid/ready channels of the HSI color fade block: input item and result.
// ----------------------------------------------------------------------------
interface hcf_in_if import hcf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [COLOR_W-1:0]         start_hue;
  logic [COLOR_W-1:0]         start_saturation;
  logic [COLOR_W-1:0]         start_intensity;
  logic [COLOR_W-1:0]         target_hue;
  logic [COLOR_W-1:0]         target_saturation;
  logic [COLOR_W-1:0]         target_intensity;
  logic [STEP_COUNT_BITS-1:0] step_count;
  logic                       shortest_path;
  logic                       positive_direction;

  modport source (
    output valid, action, start_hue, start_saturation, start_intensity,
           target_hue, target_saturation, target_intensity, step_count,
           shortest_path, positive_direction,
    input  ready
  );

  modport sink (
    input  valid, action, start_hue, start_saturation, start_intensity,
           target_hue, target_saturation, target_intensity, step_count,
           shortest_path, positive_direction,
    output ready
  );
endinterface

interface hcf_out_if import hcf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] hue;
  logic [COLOR_W-1:0] saturation;
  logic [COLOR_W-1:0] intensity;
  logic               fading;

  modport source (
    output valid, hue, saturation, intensity, fading,
    input  ready
  );

  modport sink (
    input  valid, hue, saturation, intensity, fading,
    output ready
  );
endinterface

FILE: hw/rtl/hsi_color_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsi_color_fade
// Linear fade of an HSI color in Q16 fixed point, one result per transaction.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   action, start and target color, steps, mode
//   out_o    out  valid/ready   hue, saturation, intensity, fading
//
// Tick: result valid in the cycle after the transaction is accepted.
// Start: result valid after the load, 18 restoring divide steps run in
//   parallel on each of the three color lanes, and the sign fix-up.
// A new transaction is taken only when idle and the result slot is empty
//   or being drained in the same cycle.
// Reset clears the color, the fade flag and the result slot.
// ----------------------------------------------------------------------------
module hsi_color_fade import hcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcf_in_if.sink    in_i,
  hcf_out_if.source out_o
);

  hcf_cmd_t    cmd;
  hcf_start_t  item;
  hcf_result_t result;

  assign item.start_hue          = in_i.start_hue;
  assign item.start_saturation   = in_i.start_saturation;
  assign item.start_intensity    = in_i.start_intensity;
  assign item.target_hue         = in_i.target_hue;
  assign item.target_saturation  = in_i.target_saturation;
  assign item.target_intensity   = in_i.target_intensity;
  assign item.step_count         = in_i.step_count;
  assign item.shortest_path      = in_i.shortest_path;
  assign item.positive_direction = in_i.positive_direction;

  hcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  hcf_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item),
    .result_o (result)
  );

  assign out_o.hue        = result.hue;
  assign out_o.saturation = result.saturation;
  assign out_o.intensity  = result.intensity;
  assign out_o.fading     = result.fading;

endmodule

FILE: hw/rtl/hcf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_ctrl
// Controller: input/output handshake, divider sequencing, datapath commands.
// ----------------------------------------------------------------------------
module hcf_ctrl import hcf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_action_i,
  input  logic     out_ready_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output hcf_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_SIGN = 3'b100
  } hcf_state_e;

  hcf_state_e           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.start    = accept && (in_action_i == ACT_START);
    cmd_o.tick     = accept && (in_action_i == ACT_TICK);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.div_sign = (state_q == S_SIGN);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (cmd_o.start) state_d = S_DIV;
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_LAST)) state_d = S_SIGN;
      end
      S_SIGN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.tick || cmd_o.div_sign) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == S_DIV) && (cnt_q == '0))
    else $error("start did not enter divide with a cleared count");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && (cnt_q == DIV_CNT_W'(DIV_LAST)) |=> (state_q == S_SIGN))
    else $error("divide ran past its last step");

  a_sign_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SIGN) |=> out_valid_q)
    else $error("start transaction finished without a result");

  a_busy_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !out_valid_q)
    else $error("result slot occupied while a start is in progress");
`endif

endmodule

FILE: hw/rtl/hcf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_datapath
// Color accumulators, three restoring divider lanes and the per-frame update.
// ----------------------------------------------------------------------------
module hcf_datapath import hcf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hcf_cmd_t    cmd_i,
  input  hcf_start_t  item_i,
  output hcf_result_t result_o
);

  // start preparation
  logic                       low_cur, low_tgt;
  logic [COLOR_W-1:0]         cur_c [LANES];
  logic [COLOR_W-1:0]         tgt_c [LANES];
  logic signed [DIST_W-1:0]   delta [LANES];
  logic signed [DIST_W-1:0]   absd  [LANES];
  logic [STEP_COUNT_BITS-1:0] n_start;

  // divider lanes
  logic [MAG_W-1:0]           quo_q  [LANES];
  logic [STEP_COUNT_BITS-1:0] rem_q  [LANES];
  logic                       neg_q  [LANES];
  logic [STEP_COUNT_BITS:0]   shft   [LANES];
  logic [STEP_COUNT_BITS:0]   diff   [LANES];
  logic                       ge     [LANES];
  logic [MAG_W-1:0]           quo_nx [LANES];
  logic [STEP_COUNT_BITS-1:0] rem_nx [LANES];
  logic signed [STEP_W-1:0]   qs     [LANES];
  logic signed [STEP_W-1:0]   step_nx[LANES];

  // fade state
  logic signed [STEP_W-1:0]   step_q [LANES];
  logic [COLOR_W-1:0]         end_q  [LANES];
  logic signed [ACC_W-1:0]    acc_q  [LANES];
  logic signed [ACC_W-1:0]    acc_d  [LANES];
  logic signed [ACC_W-1:0]    sum    [LANES];
  logic [STEP_COUNT_BITS-1:0] n_q;
  logic [STEP_COUNT_BITS-1:0] done_q, done_nx;
  logic                       running_q, running_d;
  logic                       last;

  always_comb begin
    low_cur = item_i.start_intensity < LOW_C;
    low_tgt = item_i.target_intensity < LOW_C;

    cur_c[LANE_HUE] = low_cur ? item_i.target_hue : item_i.start_hue;
    cur_c[LANE_SAT] = low_cur ? item_i.target_saturation : item_i.start_saturation;
    cur_c[LANE_INT] = item_i.start_intensity;
    tgt_c[LANE_HUE] = (!low_cur && low_tgt) ? item_i.start_hue : item_i.target_hue;
    tgt_c[LANE_SAT] = (!low_cur && low_tgt) ? item_i.start_saturation
                                            : item_i.target_saturation;
    tgt_c[LANE_INT] = item_i.target_intensity;

    for (int k = 0; k < LANES; k++) begin
      delta[k] = $signed(DIST_W'(tgt_c[k])) - $signed(DIST_W'(cur_c[k]));
    end

    if (item_i.shortest_path) begin
      if (delta[LANE_HUE] > HALF_D)       delta[LANE_HUE] = delta[LANE_HUE] - ONE_D;
      else if (delta[LANE_HUE] < -HALF_D) delta[LANE_HUE] = delta[LANE_HUE] + ONE_D;
    end else if (item_i.positive_direction) begin
      if (delta[LANE_HUE][DIST_W-1]) delta[LANE_HUE] = delta[LANE_HUE] + ONE_D;
    end else begin
      if (delta[LANE_HUE] > 0) delta[LANE_HUE] = delta[LANE_HUE] - ONE_D;
    end

    for (int k = 0; k < LANES; k++) begin
      absd[k] = delta[k][DIST_W-1] ? -delta[k] : delta[k];
    end

    n_start = (item_i.step_count == '0) ? STEP_COUNT_BITS'(1) : item_i.step_count;
  end

  // restoring division, one quotient bit per cycle on every lane
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      shft[k]   = {rem_q[k], quo_q[k][MAG_W-1]};
      ge[k]     = shft[k] >= {1'b0, n_q};
      diff[k]   = shft[k] - {1'b0, n_q};
      rem_nx[k] = ge[k] ? diff[k][STEP_COUNT_BITS-1:0] : shft[k][STEP_COUNT_BITS-1:0];
      quo_nx[k] = {quo_q[k][MAG_W-2:0], ge[k]};
      qs[k]      = $signed(STEP_W'(quo_q[k]));
      step_nx[k] = neg_q[k] ? -qs[k] : qs[k];
    end
  end

  // frame update
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      sum[k] = acc_q[k] + ACC_W'(step_q[k]);
    end
    if (sum[LANE_HUE] > ONE_A)       sum[LANE_HUE] = sum[LANE_HUE] - ONE_A;
    else if (sum[LANE_HUE][ACC_W-1]) sum[LANE_HUE] = sum[LANE_HUE] + ONE_A;

    done_nx = done_q + 1'b1;
    last    = done_nx >= n_q;

    acc_d     = acc_q;
    running_d = running_q;
    if (cmd_i.start) begin
      for (int k = 0; k < LANES; k++) acc_d[k] = ACC_W'(cur_c[k]);
      running_d = 1'b1;
    end else if (cmd_i.tick && running_q) begin
      for (int k = 0; k < LANES; k++) begin
        acc_d[k] = last ? ACC_W'(end_q[k]) : sum[k];
      end
      running_d = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LANES; k++) acc_q[k] <= '0;
      running_q <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      running_q <= running_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      n_q    <= n_start;
      done_q <= '0;
      for (int k = 0; k < LANES; k++) begin
        end_q[k] <= tgt_c[k];
        neg_q[k] <= delta[k][DIST_W-1];
        quo_q[k] <= absd[k][MAG_W-1:0];
        rem_q[k] <= '0;
      end
    end else if (cmd_i.tick && running_q) begin
      done_q <= done_nx;
    end
    if (cmd_i.div_step) begin
      for (int k = 0; k < LANES; k++) begin
        quo_q[k] <= quo_nx[k];
        rem_q[k] <= rem_nx[k];
      end
    end
    if (cmd_i.div_sign) begin
      for (int k = 0; k < LANES; k++) step_q[k] <= step_nx[k];
    end
  end

  assign result_o.hue        = acc_q[LANE_HUE][COLOR_W-1:0];
  assign result_o.saturation = acc_q[LANE_SAT][COLOR_W-1:0];
  assign result_o.intensity  = acc_q[LANE_INT][COLOR_W-1:0];
  assign result_o.fading     = running_q;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hsi_color_fade: start and tick transactions go in,
// a bit-accurate fade model predicts each result, and a scoreboard compares
// every output transaction field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import hcf_pkg::*;

  localparam longint ONE_L  = longint'(ONE_Q);
  localparam longint HALF_L = longint'(HALF_Q);
  localparam longint LOW_L  = longint'(LOW_THRESH);
  localparam int     RAND_ITEMS = 1850;

  typedef struct packed {
    logic       action;
    hcf_start_t args;
  } fade_item_t;

  class fade_scoreboard;
    logic signed [ACC_W-1:0]    hue_now, sat_now, int_now;
    logic signed [STEP_W-1:0]   hue_inc, sat_inc, int_inc;
    logic [COLOR_W-1:0]         goal_h, goal_s, goal_i;
    logic [STEP_COUNT_BITS-1:0] ticks_done, ticks_total;
    bit                         active;
    hcf_result_t                expected_colors[$];
    int                         errors;

    function new();
      hue_now = '0; sat_now = '0; int_now = '0;
      hue_inc = '0; sat_inc = '0; int_inc = '0;
      goal_h = '0; goal_s = '0; goal_i = '0;
      ticks_done = '0; ticks_total = '0;
      active = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction

    function void note_item(fade_item_t it);
      longint ch, cs, ci, th, ts, ti, dh, n, hn;
      hcf_result_t r;
      if (it.action == ACT_START) begin
        ch = it.args.start_hue;
        cs = it.args.start_saturation;
        ci = it.args.start_intensity;
        th = it.args.target_hue;
        ts = it.args.target_saturation;
        ti = it.args.target_intensity;
        n  = (it.args.step_count == '0) ? 1 : longint'(it.args.step_count);
        if (ci < LOW_L) begin
          ch = th;
          cs = ts;
        end else if (ti < LOW_L) begin
          th = ch;
          ts = cs;
        end
        dh = th - ch;
        if (it.args.shortest_path) begin
          if (dh > HALF_L) dh -= ONE_L;
          else if (dh < -HALF_L) dh += ONE_L;
        end else if (it.args.positive_direction) begin
          if (dh < 0) dh += ONE_L;
        end else begin
          if (dh > 0) dh -= ONE_L;
        end
        hue_inc = STEP_W'(dh / n);
        sat_inc = STEP_W'((ts - cs) / n);
        int_inc = STEP_W'((ti - ci) / n);
        goal_h = COLOR_W'(th);
        goal_s = COLOR_W'(ts);
        goal_i = COLOR_W'(ti);
        hue_now = ACC_W'(ch);
        sat_now = ACC_W'(cs);
        int_now = ACC_W'(ci);
        ticks_total = STEP_COUNT_BITS'(n);
        ticks_done = '0;
        active = 1'b1;
      end else if (active) begin
        hn = longint'(hue_now) + longint'(hue_inc);
        if (hn > ONE_L) hn -= ONE_L;
        else if (hn < 0) hn += ONE_L;
        hue_now = ACC_W'(hn);
        sat_now = ACC_W'(longint'(sat_now) + longint'(sat_inc));
        int_now = ACC_W'(longint'(int_now) + longint'(int_inc));
        ticks_done++;
        if (ticks_done >= ticks_total) begin
          hue_now = ACC_W'(goal_h);
          sat_now = ACC_W'(goal_s);
          int_now = ACC_W'(goal_i);
          active = 1'b0;
        end
      end
      r.hue        = hue_now[COLOR_W-1:0];
      r.saturation = sat_now[COLOR_W-1:0];
      r.intensity  = int_now[COLOR_W-1:0];
      r.fading     = active;
      expected_colors.push_back(r);
    endfunction

    function void compare_field(string what, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(hcf_result_t got);
      hcf_result_t want;
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual h=%0d s=%0d i=%0d f=%0d",
                 $time, got.hue, got.saturation, got.intensity, got.fading);
        errors++;
      end else begin
        want = expected_colors.pop_front();
        compare_field("hue", want.hue, got.hue);
        compare_field("saturation", want.saturation, got.saturation);
        compare_field("intensity", want.intensity, got.intensity);
        compare_field("fading", COLOR_W'(want.fading), COLOR_W'(got.fading));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  hcf_in_if  in_if ();
  hcf_out_if out_if ();

  hsi_color_fade dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  fade_scoreboard fade_sb = new();
  int  items_sent;
  bit  tx_quiet;
  bit  rx_quiet;
  int  results_seen;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    fade_item_t  it;
    hcf_result_t res;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        it.action                  = in_if.action;
        it.args.start_hue          = in_if.start_hue;
        it.args.start_saturation   = in_if.start_saturation;
        it.args.start_intensity    = in_if.start_intensity;
        it.args.target_hue         = in_if.target_hue;
        it.args.target_saturation  = in_if.target_saturation;
        it.args.target_intensity   = in_if.target_intensity;
        it.args.step_count         = in_if.step_count;
        it.args.shortest_path      = in_if.shortest_path;
        it.args.positive_direction = in_if.positive_direction;
        fade_sb.note_item(it);
      end
      if (out_if.valid && out_if.ready) begin
        res.hue        = out_if.hue;
        res.saturation = out_if.saturation;
        res.intensity  = out_if.intensity;
        res.fading     = out_if.fading;
        fade_sb.check_result(res);
      end
    end
  end

  // result drain with random stalls and one long hold-off
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    results_seen = 0;
    rx_quiet = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 16);
      if (results_seen == 400) stall = 400;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      results_seen++;
    end
  end

  task automatic send_item(fade_item_t it);
    int gap;
    if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid              <= 1'b1;
    in_if.action             <= it.action;
    in_if.start_hue          <= it.args.start_hue;
    in_if.start_saturation   <= it.args.start_saturation;
    in_if.start_intensity    <= it.args.start_intensity;
    in_if.target_hue         <= it.args.target_hue;
    in_if.target_saturation  <= it.args.target_saturation;
    in_if.target_intensity   <= it.args.target_intensity;
    in_if.step_count         <= it.args.step_count;
    in_if.shortest_path      <= it.args.shortest_path;
    in_if.positive_direction <= it.args.positive_direction;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  function automatic fade_item_t noise_item();
    fade_item_t it;
    it.action                  = 1'($urandom);
    it.args.start_hue          = COLOR_W'($urandom);
    it.args.start_saturation   = COLOR_W'($urandom);
    it.args.start_intensity    = COLOR_W'($urandom);
    it.args.target_hue         = COLOR_W'($urandom);
    it.args.target_saturation  = COLOR_W'($urandom);
    it.args.target_intensity   = COLOR_W'($urandom);
    it.args.step_count         = STEP_COUNT_BITS'($urandom_range(0, 12));
    it.args.shortest_path      = 1'($urandom);
    it.args.positive_direction = 1'($urandom);
    return it;
  endfunction

  task automatic send_ticks(int count);
    fade_item_t it;
    repeat (count) begin
      it = noise_item();
      it.action = ACT_TICK;
      send_item(it);
    end
  endtask

  task automatic start_fade(int h, int s, int i, int th, int ts, int ti, int n,
                            bit sp, bit pd);
    fade_item_t it;
    it.action                  = ACT_START;
    it.args.start_hue          = COLOR_W'(h);
    it.args.start_saturation   = COLOR_W'(s);
    it.args.start_intensity    = COLOR_W'(i);
    it.args.target_hue         = COLOR_W'(th);
    it.args.target_saturation  = COLOR_W'(ts);
    it.args.target_intensity   = COLOR_W'(ti);
    it.args.step_count         = STEP_COUNT_BITS'(n);
    it.args.shortest_path      = sp;
    it.args.positive_direction = pd;
    send_item(it);
  endtask

  function automatic int pick_level();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return int'(ONE_Q);
      2:       return int'(COLOR_W'($urandom));
      3:       return int'(LOW_THRESH) - 1 + int'($urandom_range(0, 1));
      4:       return (1 << COLOR_W) - 1;
      5:       return int'($urandom_range(0, LOW_THRESH));
      default: return int'($urandom_range(0, ONE_Q));
    endcase
  endfunction

  function automatic int pick_steps();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return int'($urandom_range(13, 200));
      2:       return (1 << STEP_COUNT_BITS) - 1;
      3:       return int'($urandom_range(201, (1 << STEP_COUNT_BITS) - 2));
      default: return int'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin
    int n, n_eff, ticks, kind;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.action <= ACT_TICK;
    in_if.start_hue <= '0;
    in_if.start_saturation <= '0;
    in_if.start_intensity <= '0;
    in_if.target_hue <= '0;
    in_if.target_saturation <= '0;
    in_if.target_intensity <= '0;
    in_if.step_count <= '0;
    in_if.shortest_path <= 1'b0;
    in_if.positive_direction <= 1'b0;
    items_sent = 0;
    tx_quiet = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick while idle
    send_ticks(1);
    // full-scale extremes
    start_fade(0, 0, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 2, 1'b1, 1'b0);
    send_ticks(2);
    // dark start takes target hue and saturation
    start_fade(1234, 50000, LOW_THRESH - 1, 40000, 20000, ONE_Q, 2, 1'b1, 1'b0);
    send_ticks(2);
    // dark target keeps start hue and saturation
    start_fade(30000, 10000, LOW_THRESH, 5000, 60000, LOW_THRESH - 1, 2, 1'b0, 1'b1);
    send_ticks(2);
    // shortest path across zero, hue wraps above one
    start_fade(60000, 1000, ONE_Q, 1000, 65000, 7000, 3, 1'b1, 1'b0);
    send_ticks(3);
    // forced positive direction
    start_fade(40000, 30000, 40000, 30000, 40000, 30000, 2, 1'b0, 1'b1);
    send_ticks(2);
    // forced negative direction, hue wraps below zero
    start_fade(1000, 0, 20000, 20000, ONE_Q, 0, 3, 1'b0, 1'b0);
    send_ticks(3);
    // out-of-range values, longest fade, restart mid-fade with zero steps
    start_fade((1 << COLOR_W) - 1, (1 << COLOR_W) - 1, (1 << COLOR_W) - 1,
               0, 0, (1 << COLOR_W) - 1, (1 << STEP_COUNT_BITS) - 1, 1'b0, 1'b1);
    send_ticks(2);
    start_fade(0, 0, ONE_Q, HALF_Q, ONE_Q, 0, 0, 1'b1, 1'b0);
    send_ticks(1);
    // hue lands exactly on one and is kept
    start_fade(49152, 0, ONE_Q, 16384, 0, ONE_Q, 4, 1'b0, 1'b1);
    send_ticks(4);

    while (items_sent < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_item(noise_item());
      end else begin
        n = pick_steps();
        n_eff = (n == 0) ? 1 : n;
        start_fade(pick_level(), pick_level(), pick_level(), pick_level(), pick_level(),
                   pick_level(), n, 1'($urandom), 1'($urandom));
        if (n_eff > 200) ticks = $urandom_range(0, 5);
        else if (kind == 1) ticks = $urandom_range(0, n_eff - 1);
        else ticks = n_eff + $urandom_range(0, 2);
        send_ticks(ticks);
      end
    end
    in_if.valid <= 1'b0;

    while (fade_sb.pending() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fade_sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
